// ===== design/gsfp_pkg.sv =====
package gsfp_pkg;

    localparam logic [7:0] START_BYTE_0   = 8'h42;
    localparam logic [7:0] START_BYTE_1   = 8'h4D;
    localparam logic [7:0] FRAME_LENGTH   = 8'h08;
    localparam logic [7:0] GAS_TYPE_RESET = 8'h14;

    // position of the next byte expected inside a frame
    localparam logic [3:0] POS_MARK     = 4'd1;
    localparam logic [3:0] POS_LENGTH   = 4'd2;
    localparam logic [3:0] POS_GAS      = 4'd3;
    localparam logic [3:0] POS_SCALE    = 4'd5;
    localparam logic [3:0] POS_CONC_HI  = 4'd6;
    localparam logic [3:0] POS_CONC_LO  = 4'd7;
    localparam logic [3:0] POS_CHK_HI   = 4'd8;
    localparam logic [3:0] POS_CHK_LO   = 4'd9;
    localparam logic [3:0] POS_SUM_LAST = 4'd7;

    localparam logic [7:0] SCALE_MIN = 8'd1;
    localparam logic [7:0] SCALE_MAX = 8'd4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_SCALE    = 2'd2
    } status_t;

endpackage

// ===== design/gas_sensor_frame_parser.sv =====
// Channel   Direction  Handshake              Word
// in        input      in_valid / in_ready    rx_byte
// out       output     out_valid / out_ready  concentration, scale_exponent, frame_status
// cfg       input      cfg_valid / cfg_ready  cfg_data (expected gas type)
//
// One byte per cycle sustained while no result is stalled; a byte is held in an
// input register, parsed in the next cycle unless a stalled result holds it, and
// a frame result is loaded into the output register when the last checksum byte is parsed.
// Reset (rst_n low, asynchronous) puts the parser in hunt mode and the expected
// gas type to 0x14.
// A result held by out_ready low stalls only the byte that ends the next frame.
module gas_sensor_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] concentration,
    output logic [1:0]  scale_exponent,
    output logic [1:0]  frame_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import gsfp_pkg::*;

    logic        byte_full_reg, byte_full_next;
    logic [7:0]  byte_reg;
    logic [7:0]  gas_type_reg;
    logic        hunting_reg, hunting_next;
    logic [3:0]  pos_reg, pos_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  scale_reg, scale_next;
    logic [15:0] value_reg, value_next;
    logic [7:0]  chk_hi_reg, chk_hi_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] conc_reg, conc_next;
    logic [1:0]  expo_reg, expo_next;
    status_t     status_reg, status_next;

    logic        frame_end;
    logic        advance;
    logic        emit;
    logic [15:0] received;
    logic        scale_ok;

    assign frame_end = !hunting_reg && (pos_reg == POS_CHK_LO);
    assign advance   = byte_full_reg && (!frame_end || !out_valid_reg || out_ready);
    assign emit      = advance && frame_end;
    assign in_ready  = !byte_full_reg || advance;
    assign cfg_ready = 1'b1;

    assign received = {chk_hi_reg, byte_reg};
    assign scale_ok = (scale_reg >= SCALE_MIN) && (scale_reg <= SCALE_MAX);

    always_comb
    begin
        byte_full_next = byte_full_reg;
        if (in_valid && in_ready)
        begin
            byte_full_next = 1'b1;
        end
        else if (advance)
        begin
            byte_full_next = 1'b0;
        end
    end

    always_comb
    begin
        hunting_next = hunting_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        scale_next   = scale_reg;
        value_next   = value_reg;
        chk_hi_next  = chk_hi_reg;
        if (advance)
        begin
            if (hunting_reg)
            begin
                if (byte_reg == START_BYTE_0)
                begin
                    hunting_next = 1'b0;
                    pos_next     = POS_MARK;
                    sum_next     = {8'd0, byte_reg};
                end
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
                if (pos_reg <= POS_SUM_LAST)
                begin
                    sum_next = sum_reg + {8'd0, byte_reg};
                end
                unique case (pos_reg)
                    POS_MARK:
                    begin
                        if (byte_reg != START_BYTE_1)
                        begin
                            hunting_next = 1'b1;
                        end
                    end
                    POS_LENGTH:
                    begin
                        if (byte_reg != FRAME_LENGTH)
                        begin
                            hunting_next = 1'b1;
                        end
                    end
                    POS_GAS:
                    begin
                        if (byte_reg != gas_type_reg)
                        begin
                            hunting_next = 1'b1;
                        end
                    end
                    POS_SCALE:   scale_next  = byte_reg;
                    POS_CONC_HI: value_next  = {byte_reg, 8'd0};
                    POS_CONC_LO: value_next  = {value_reg[15:8], byte_reg};
                    POS_CHK_HI:  chk_hi_next = byte_reg;
                    POS_CHK_LO:  hunting_next = 1'b1;
                    default:     ;
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        conc_next      = conc_reg;
        expo_next      = expo_reg;
        status_next    = status_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            conc_next      = 16'd0;
            expo_next      = 2'd0;
            priority if (received != sum_reg)
            begin
                status_next = ST_CHECKSUM;
            end
            else if (!scale_ok)
            begin
                status_next = ST_SCALE;
            end
            else
            begin
                status_next = ST_OK;
                conc_next   = value_reg;
                expo_next   = scale_reg[1:0] - 2'd1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_full_reg <= 1'b0;
            gas_type_reg  <= GAS_TYPE_RESET;
            hunting_reg   <= 1'b1;
            pos_reg       <= 4'd0;
            sum_reg       <= 16'd0;
            scale_reg     <= 8'd0;
            value_reg     <= 16'd0;
            chk_hi_reg    <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            byte_full_reg <= byte_full_next;
            if (cfg_valid && cfg_ready)
            begin
                gas_type_reg <= cfg_data;
            end
            hunting_reg   <= hunting_next;
            pos_reg       <= hunting_next ? 4'd0 : pos_next;
            sum_reg       <= sum_next;
            scale_reg     <= scale_next;
            value_reg     <= value_next;
            chk_hi_reg    <= chk_hi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
        conc_reg   <= conc_next;
        expo_reg   <= expo_next;
        status_reg <= status_next;
    end

    assign out_valid      = out_valid_reg;
    assign concentration  = conc_reg;
    assign scale_exponent = expo_reg;
    assign frame_status   = status_reg;

endmodule

// ===== design/gsfp_checker.sv =====
module gsfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] concentration,
    input logic [1:0]  scale_exponent,
    input logic [1:0]  frame_status
);
    import gsfp_pkg::*;

    // failed frames carry no measurement
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_status != ST_OK) |-> (concentration == 16'd0)
            && (scale_exponent == 2'd0))
        else $error("failed frame carries nonzero measurement");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_status == ST_OK) || (frame_status == ST_CHECKSUM)
            || (frame_status == ST_SCALE))
        else $error("frame status code out of range");

    // a fresh result needs a byte to have been taken earlier
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a preceding input word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(concentration)
            && $stable(scale_exponent) && $stable(frame_status))
        else $error("stalled result changed");

endmodule

bind gas_sensor_frame_parser gsfp_checker u_gsfp_checker (.*);
